FILE: rtl/core/cidfsk_pkg.sv
// ----------------------------------------------------------------------------
// cidfsk_pkg
// Shared constants and types of the caller id fsk frame receiver.
// ----------------------------------------------------------------------------
package cidfsk_pkg;

	localparam int BUF_DEPTH_DEF = 256;

	localparam int STATUS_W = 16;
	localparam int BYTE_W = 8;
	localparam int RUN_W = 4;
	localparam int PHASE_W = 2;

	localparam int FSK_READY_BIT = 6;

	localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'h55;
	localparam logic [BYTE_W-1:0] TYPE_A = 8'h02;
	localparam logic [BYTE_W-1:0] TYPE_B = 8'h04;
	localparam logic [BYTE_W-1:0] SHORT_LIMIT = 8'h10;
	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

	localparam logic [RUN_W-1:0] PREAMBLE_NEEDED_RST = 4'd3;

	localparam logic [PHASE_W-1:0] PHASE_PREAMBLE = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_TYPE = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_LENGTH = 2'd2;
	localparam logic [PHASE_W-1:0] PHASE_DIGITS = 2'd3;

	typedef struct packed {
		logic digit_valid;
		logic [BYTE_W-1:0] digit_value;
		logic [BYTE_W-1:0] digit_index;
		logic message_done;
		logic call_received;
		logic [PHASE_W-1:0] frame_phase;
	} result_t;

endpackage

FILE: rtl/core/cidfsk_parser.sv
// ----------------------------------------------------------------------------
// cidfsk_parser
// Frame state machine: preamble, type, length and digit phases, with the
// result of each beat held in a register.
// ----------------------------------------------------------------------------
module cidfsk_parser
	import cidfsk_pkg::*;
#(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [STATUS_W-1:0] status_word,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [RUN_W-1:0] preamble_needed,
	output result_t result
);

	localparam int LEN_W = $clog2(BUF_DEPTH + 1);

	typedef enum logic [PHASE_W-1:0] {
		ST_PREAMBLE = PHASE_PREAMBLE,
		ST_TYPE = PHASE_TYPE,
		ST_LENGTH = PHASE_LENGTH,
		ST_DIGITS = PHASE_DIGITS
	} phase_t;

	phase_t phase_q, phase_d;
	logic [RUN_W-1:0] run_q, run_d, run_inc;
	logic [LEN_W-1:0] length_q, length_d;
	logic [LEN_W-1:0] taken_q, taken_d;
	logic [LEN_W+BYTE_W-1:0] taken_ext;
	logic received_q, received_d;
	result_t result_d, result_q;

	assign run_inc = run_q + 1'b1;
	assign taken_ext = {{BYTE_W{1'b0}}, taken_q};

	always_comb begin
		phase_d = phase_q;
		run_d = run_q;
		length_d = length_q;
		taken_d = taken_q;
		received_d = received_q;
		result_d = '0;
		if (status_word[FSK_READY_BIT]) begin
			unique case (phase_q)
				ST_PREAMBLE: begin
					if (rx_byte == PREAMBLE_BYTE) begin
						if (run_inc >= preamble_needed) begin
							run_d = '0;
							phase_d = ST_TYPE;
						end else begin
							run_d = run_inc;
						end
					end else begin
						run_d = '0;
					end
				end
				ST_TYPE: begin
					if (rx_byte == TYPE_A || rx_byte == TYPE_B) begin
						phase_d = ST_LENGTH;
					end
				end
				ST_LENGTH: begin
					if (rx_byte < SHORT_LIMIT) begin
						length_d = {{(LEN_W-4){1'b0}}, rx_byte[3:0]};
					end else begin
						length_d = LEN_W'(BUF_DEPTH);
					end
					taken_d = '0;
					phase_d = ST_DIGITS;
				end
				ST_DIGITS: begin
					if (taken_q < length_q) begin
						result_d.digit_valid = 1'b1;
						result_d.digit_value = rx_byte - ASCII_ZERO;
						result_d.digit_index = taken_ext[BYTE_W-1:0];
						taken_d = taken_q + 1'b1;
					end else begin
						received_d = 1'b1;
						result_d.message_done = 1'b1;
						phase_d = ST_PREAMBLE;
					end
				end
			endcase
		end
		result_d.call_received = received_d;
		result_d.frame_phase = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ST_PREAMBLE;
			run_q <= '0;
			length_q <= '0;
			taken_q <= '0;
			received_q <= 1'b0;
			result_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			run_q <= run_d;
			length_q <= length_d;
			taken_q <= taken_d;
			received_q <= received_d;
			result_q <= result_d;
		end
	end

	assign result = result_q;

endmodule

FILE: rtl/core/caller_id_fsk_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// caller_id_fsk_frame_receiver_top
// Caller id fsk frame receiver: one status word and byte in, one result out.
// the result beat is registered and is shown in the cycle after its input beat is taken
// throughput: one beat per cycle, set by the single result register
// a new beat is taken whenever the result register is empty or being drained
// reset clears frame state, the received flag and the result register;
// preamble_needed returns to 3
// ----------------------------------------------------------------------------
module caller_id_fsk_frame_receiver_top
	import cidfsk_pkg::*;
#(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [RUN_W-1:0] cfg_wr_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [STATUS_W-1:0] status_word,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic digit_valid,
	output logic [BYTE_W-1:0] digit_value,
	output logic [BYTE_W-1:0] digit_index,
	output logic message_done,
	output logic call_received,
	output logic [PHASE_W-1:0] frame_phase
);

	logic [RUN_W-1:0] preamble_needed_q;
	logic out_valid_q;
	logic accept;
	result_t result;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_needed_q <= PREAMBLE_NEEDED_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				preamble_needed_q <= cfg_wr_data;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	cidfsk_parser #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(accept),
		.status_word(status_word),
		.rx_byte(rx_byte),
		.preamble_needed(preamble_needed_q),
		.result(result)
	);

	assign out_valid = out_valid_q;
	assign digit_valid = result.digit_valid;
	assign digit_value = result.digit_value;
	assign digit_index = result.digit_index;
	assign message_done = result.message_done;
	assign call_received = result.call_received;
	assign frame_phase = result.frame_phase;

endmodule

FILE: rtl/core/cidfsk_checker.sv
// ----------------------------------------------------------------------------
// cidfsk_checker
// Port level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module cidfsk_checker
	import cidfsk_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_ready,
	input  logic out_valid,
	input  logic out_ready,
	input  logic digit_valid,
	input  logic [BYTE_W-1:0] digit_value,
	input  logic [BYTE_W-1:0] digit_index,
	input  logic message_done,
	input  logic call_received,
	input  logic [PHASE_W-1:0] frame_phase
);

	// stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_valid)
			&& $stable(digit_value) && $stable(digit_index)
			&& $stable(message_done) && $stable(call_received)
			&& $stable(frame_phase))
		else $error("stalled result beat changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_valid |-> frame_phase == PHASE_DIGITS && !message_done)
		else $error("digit outside digit phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_done |-> call_received && frame_phase == PHASE_PREAMBLE)
		else $error("message end without flag or phase return");

endmodule

bind caller_id_fsk_frame_receiver_top cidfsk_checker u_cidfsk_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.digit_valid(digit_valid),
	.digit_value(digit_value),
	.digit_index(digit_index),
	.message_done(message_done),
	.call_received(call_received),
	.frame_phase(frame_phase)
);
